@@ design/ola_pkg.sv @@
// ----------------------------------------------------------------------------
// ola_pkg
// Shared types and constants of the ordered list with append and remove.
// ----------------------------------------------------------------------------
package ola_pkg;

  localparam int CAPACITY    = 64;
  localparam int ENTRY_WIDTH = 32;

  localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int VALUE_W     = 32;
  localparam int COUNT_OUT_W = 7;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef logic [ENTRY_WIDTH-1:0] entry_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CNT_W-1:0]       count_t;

  typedef struct packed {
    logic               command;
    logic [VALUE_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [COUNT_OUT_W-1:0] entry_count;
  } result_t;

endpackage

@@ design/ordered_list_append_remove.sv @@
// ----------------------------------------------------------------------------
// ordered_list_append_remove
// Ordered list in a single-port-read, single-port-write memory. Append writes
// at the end; remove scans for the first match and shifts later entries down.
// ----------------------------------------------------------------------------
//  channel   direction  payload     handshake
//  request   in         request_t   request_valid / request_stall
//  result    out        result_t    result_valid / result_stall
//
//  one command at a time; request_stall is high from accept until the
//  result is loaded into the output register
//  after accept, append goes straight to the done state; remove scans for
//  a match and, when found, shifts the later entries down, with one memory
//  read per cycle for the scan and then for the shift
//  reset clears the count and control; memory contents need no clearing
//  a stalled result holds while the next command is accepted and worked on
module ordered_list_append_remove
  import ola_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  request_t request,
  input  logic     request_valid,
  output logic     request_stall,
  output result_t  result,
  output logic     result_valid,
  input  logic     result_stall
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t  state;
  count_t  count;
  count_t  rd_idx;
  addr_t   pend_idx;
  logic    pend_v;
  entry_t  value_q;
  result_t done_res;

  entry_t  mem [CAPACITY];
  entry_t  rd_data;

  logic    wr_en;
  addr_t   wr_addr;
  entry_t  wr_data;
  addr_t   rd_addr;
  logic    accept;
  logic    match;
  logic    more;

  assign accept        = request_valid && !request_stall;
  assign request_stall = (state != S_IDLE);
  assign match         = pend_v && (rd_data == value_q);
  assign more          = (rd_idx != count);
  assign rd_addr       = rd_idx[ADDR_W-1:0];

  // memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[ADDR_W-1:0];
    wr_data = entry_t'(request.value);
    case (state)
      S_IDLE: begin
        wr_en = accept && (request.command == CMD_APPEND) &&
                (count != count_t'(CAPACITY));
      end
      S_SHIFT: begin
        wr_en   = pend_v;
        wr_addr = addr_t'(pend_idx - 1'b1);
        wr_data = rd_data;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      rd_idx       <= '0;
      pend_v       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            value_q <= entry_t'(request.value);
            rd_idx  <= '0;
            pend_v  <= 1'b0;
            if (request.command == CMD_APPEND) begin
              if (count == count_t'(CAPACITY)) begin
                done_res.status      <= ST_FULL;
                done_res.entry_count <= COUNT_OUT_W'(count);
              end else begin
                count                <= count_t'(count + 1'b1);
                done_res.status      <= ST_OK;
                done_res.entry_count <= COUNT_OUT_W'(count_t'(count + 1'b1));
              end
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (match) begin
            rd_idx <= count_t'(count_t'(pend_idx) + 1'b1);
            pend_v <= 1'b0;
            state  <= S_SHIFT;
          end else if (!more) begin
            pend_v               <= 1'b0;
            done_res.status      <= ST_NOT_FOUND;
            done_res.entry_count <= COUNT_OUT_W'(count);
            state                <= S_DONE;
          end else begin
            pend_idx <= rd_addr;
            pend_v   <= 1'b1;
            rd_idx   <= count_t'(rd_idx + 1'b1);
          end
        end
        S_SHIFT: begin
          if (more) begin
            pend_idx <= rd_addr;
            pend_v   <= 1'b1;
            rd_idx   <= count_t'(rd_idx + 1'b1);
          end else begin
            pend_v               <= 1'b0;
            count                <= count_t'(count - 1'b1);
            done_res.status      <= ST_OK;
            done_res.entry_count <= COUNT_OUT_W'(count_t'(count - 1'b1));
            state                <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result       <= done_res;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/ola_check.sv @@
// ----------------------------------------------------------------------------
// ola_check
// Port-level checks of the ordered list, bound to the top level.
// ----------------------------------------------------------------------------
module ola_check
  import ola_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input request_t request,
  input logic     request_valid,
  input logic     request_stall,
  input result_t  result,
  input logic     result_valid,
  input logic     result_stall
);

  // held result beat stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == ST_OK || result.status == ST_FULL ||
                      result.status == ST_NOT_FOUND))
    else $error("bad status code");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.entry_count <= COUNT_OUT_W'(CAPACITY))
    else $error("count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_FULL |->
      result.entry_count == COUNT_OUT_W'(CAPACITY))
    else $error("full reported below capacity");

  // one command in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    request_valid && !request_stall |=> request_stall)
    else $error("second command taken while busy");

endmodule

bind ordered_list_append_remove ola_check u_ola_check (.*);
